// ===== sv/rmq_pkg.sv =====
// Shared types and constants for the rotation matrix to quaternion block.
// No dependencies; every other file imports this package.
package rmq_pkg;

  localparam int FRAC_BITS = 14;
  localparam int SQRT_CELLS = 18;
  localparam int DIV_CELLS = 15;
  localparam logic [14:0] Q_LIMIT = 15'(1 << FRAC_BITS);
  localparam logic signed [17:0] ONE = 18'sd16384;

  typedef struct packed {
    logic signed [15:0] row0_col0;
    logic signed [15:0] row0_col1;
    logic signed [15:0] row0_col2;
    logic signed [15:0] row1_col0;
    logic signed [15:0] row1_col1;
    logic signed [15:0] row1_col2;
    logic signed [15:0] row2_col0;
    logic signed [15:0] row2_col1;
    logic signed [15:0] row2_col2;
  } in_t;

  typedef struct packed {
    logic signed [15:0] quat_w;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
    logic               invalid;
  } out_t;

  // Beat moving through the square-root cells.
  typedef struct packed {
    logic             vld;
    logic             bad;
    logic [3:0]       neg;
    logic [3:0][16:0] mag;
    logic [35:0]      rem;
    logic [35:0]      root;
  } sqs_t;

  // Beat moving through the divider cells, four lanes side by side.
  typedef struct packed {
    logic             vld;
    logic             bad;
    logic [3:0]       neg;
    logic [17:0]      len;
    logic [3:0][14:0] num;
    logic [3:0][17:0] rem;
    logic [3:0][14:0] quo;
  } dvs_t;

endpackage

// ===== sv/rmq_sqrt_cell.sv =====
// One step of the integer square root: settles one result bit per beat.
// Depends on rmq_pkg.
module rmq_sqrt_cell (
  input  logic          clk,
  input  logic          rst,
  input  logic [4:0]    step,
  input  rmq_pkg::sqs_t d,
  output rmq_pkg::sqs_t q
);
  import rmq_pkg::*;

  logic [35:0] bitv;
  logic [35:0] trial;
  sqs_t        q_next;

  always_comb begin
    bitv   = 36'(1) << {step, 1'b0};
    trial  = d.root + bitv;
    q_next = d;
    if (d.rem >= trial) begin
      q_next.rem  = d.rem - trial;
      q_next.root = (d.root >> 1) + bitv;
    end else begin
      q_next.root = d.root >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q <= '0;
    end else begin
      q <= q_next;
    end
  end

endmodule

// ===== sv/rmq_div_cell.sv =====
// One restoring division step on four lanes: one quotient bit per lane per beat.
// Depends on rmq_pkg.
module rmq_div_cell (
  input  logic          clk,
  input  logic          rst,
  input  rmq_pkg::dvs_t d,
  output rmq_pkg::dvs_t q
);
  import rmq_pkg::*;

  logic [3:0][18:0] rem2;
  logic [3:0]       ge;
  dvs_t             q_next;

  always_comb begin
    q_next = d;
    for (int i = 0; i < 4; i++) begin
      rem2[i] = {d.rem[i], d.num[i][14]};
      ge[i]   = rem2[i] >= {1'b0, d.len};
      q_next.rem[i] = ge[i] ? 18'(rem2[i] - {1'b0, d.len}) : rem2[i][17:0];
      q_next.num[i] = {d.num[i][13:0], 1'b0};
      q_next.quo[i] = {d.quo[i][13:0], ge[i]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q <= '0;
    end else begin
      q <= q_next;
    end
  end

endmodule

// ===== sv/rotation_matrix_to_quaternion.sv =====
// Top level of the rotation matrix to quaternion converter.
// Depends on rmq_pkg, rmq_sqrt_cell and rmq_div_cell.
//
// Usage: drive the nine Q1.14 matrix elements on item and raise start for
// one cycle per matrix. busy is held low, so a beat is accepted at every
// edge where start is high: one matrix per clock, back to back.
// The quaternion appears on result with done high for exactly one cycle,
// once the beat has passed the whole chain. The receiver cannot stall; results
// leave in acceptance order, one per cycle at most.
// Latency is set by the chain: three front stages (branch select, squares,
// sum), 18 square-root cells, one divider set-up stage, 15 divider cells
// of four lanes each, and the output register.
// The branch vector is normalized by floor(sqrt(sum of squares)), each
// part rounded to nearest and clamped to one. A non-positive root argument
// or a zero length gives zeros with invalid set.
// Synchronous reset clears every valid bit in the chain; beats in flight
// are dropped and done stays low until new beats arrive.
module rotation_matrix_to_quaternion (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  rmq_pkg::in_t  item,
  output logic          done,
  output rmq_pkg::out_t result
);
  import rmq_pkg::*;

  // Front stage: pick the branch and form the unnormalized vector.
  logic signed [17:0]      m00, m01, m02, m10, m11, m12, m20, m21, m22;
  logic signed [17:0]      trace, t;
  logic signed [3:0][17:0] v;

  assign busy = 1'b0;

  always_comb begin
    m00 = 18'(item.row0_col0);
    m01 = 18'(item.row0_col1);
    m02 = 18'(item.row0_col2);
    m10 = 18'(item.row1_col0);
    m11 = 18'(item.row1_col1);
    m12 = 18'(item.row1_col2);
    m20 = 18'(item.row2_col0);
    m21 = 18'(item.row2_col1);
    m22 = 18'(item.row2_col2);
    trace = m00 + m11 + m22;
    if (trace > 0) begin
      t = ONE + trace;
      v[0] = t; v[1] = m21 - m12; v[2] = m02 - m20; v[3] = m10 - m01;
    end else if (m00 > m11 && m00 > m22) begin
      t = ONE + m00 - m11 - m22;
      v[0] = m21 - m12; v[1] = t; v[2] = m01 + m10; v[3] = m02 + m20;
    end else if (m11 > m22) begin
      t = ONE + m11 - m00 - m22;
      v[0] = m02 - m20; v[1] = m01 + m10; v[2] = t; v[3] = m12 + m21;
    end else begin
      t = ONE + m22 - m00 - m11;
      v[0] = m10 - m01; v[1] = m02 + m20; v[2] = m12 + m21; v[3] = t;
    end
  end

  logic             a_vld, a_bad;
  logic [3:0]       a_neg;
  logic [3:0][16:0] a_mag;

  always_ff @(posedge clk) begin
    a_bad <= (t <= 0);
    for (int i = 0; i < 4; i++) begin
      a_neg[i] <= v[i][17];
      a_mag[i] <= v[i][17] ? 17'(-v[i]) : v[i][16:0];
    end
    if (rst) begin
      a_vld <= 1'b0;
    end else begin
      a_vld <= start && !busy;
    end
  end

  // Squares, one multiplier per lane.
  logic             b_vld, b_bad;
  logic [3:0]       b_neg;
  logic [3:0][16:0] b_mag;
  logic [3:0][33:0] b_sq;

  always_ff @(posedge clk) begin
    b_bad <= a_bad;
    b_neg <= a_neg;
    b_mag <= a_mag;
    for (int i = 0; i < 4; i++) begin
      b_sq[i] <= a_mag[i] * a_mag[i];
    end
    if (rst) begin
      b_vld <= 1'b0;
    end else begin
      b_vld <= a_vld;
    end
  end

  // Sum of squares feeds the first root cell.
  sqs_t sq_chain [SQRT_CELLS+1];

  always_ff @(posedge clk) begin
    sq_chain[0].bad  <= b_bad;
    sq_chain[0].neg  <= b_neg;
    sq_chain[0].mag  <= b_mag;
    sq_chain[0].rem  <= 36'(b_sq[0]) + 36'(b_sq[1]) + 36'(b_sq[2]) + 36'(b_sq[3]);
    sq_chain[0].root <= '0;
    if (rst) begin
      sq_chain[0].vld <= 1'b0;
    end else begin
      sq_chain[0].vld <= b_vld;
    end
  end

  // Cell k settles the root bit of weight 2^(17-k).
  for (genvar k = 0; k < SQRT_CELLS; k++) begin : g_sqrt
    rmq_sqrt_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .step (5'(SQRT_CELLS - 1 - k)),
      .d    (sq_chain[k]),
      .q    (sq_chain[k+1])
    );
  end

  // Divider set-up: numerator is mag * 2^14 plus half the length for rounding.
  sqs_t             sq_end;
  logic [17:0]      len;
  logic [3:0][31:0] numer;
  dvs_t             dv_chain [DIV_CELLS+1];

  assign sq_end = sq_chain[SQRT_CELLS];
  assign len    = sq_end.root[17:0];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      numer[i] = {1'b0, sq_end.mag[i], 14'b0} + 32'(len >> 1);
    end
  end

  always_ff @(posedge clk) begin
    dv_chain[0].bad <= sq_end.bad || (len == '0);
    dv_chain[0].neg <= sq_end.neg;
    dv_chain[0].len <= len;
    for (int i = 0; i < 4; i++) begin
      dv_chain[0].rem[i] <= {1'b0, numer[i][31:15]};
      dv_chain[0].num[i] <= numer[i][14:0];
      dv_chain[0].quo[i] <= '0;
    end
    if (rst) begin
      dv_chain[0].vld <= 1'b0;
    end else begin
      dv_chain[0].vld <= sq_end.vld;
    end
  end

  for (genvar k = 0; k < DIV_CELLS; k++) begin : g_div
    rmq_div_cell u_cell (
      .clk (clk),
      .rst (rst),
      .d   (dv_chain[k]),
      .q   (dv_chain[k+1])
    );
  end

  // Clamp, restore signs and register the result.
  dvs_t             dv_end;
  logic [3:0][14:0] mag_q;
  logic [3:0][15:0] part;

  assign dv_end = dv_chain[DIV_CELLS];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      mag_q[i] = (dv_end.quo[i] > Q_LIMIT) ? Q_LIMIT : dv_end.quo[i];
      part[i]  = dv_end.bad ? 16'd0
               : (dv_end.neg[i] ? 16'(-{1'b0, mag_q[i]}) : {1'b0, mag_q[i]});
    end
  end

  always_ff @(posedge clk) begin
    result.quat_w  <= part[0];
    result.quat_x  <= part[1];
    result.quat_y  <= part[2];
    result.quat_z  <= part[3];
    result.invalid <= dv_end.bad;
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= dv_end.vld;
    end
  end

`ifndef SYNTH
  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    done && result.invalid |-> result.quat_w == 0 && result.quat_x == 0 &&
                               result.quat_y == 0 && result.quat_z == 0)
    else $error("invalid result carries nonzero parts");

  a_part_range: assert property (@(posedge clk) disable iff (rst)
    done |-> result.quat_w <= 16384 && result.quat_w >= -16384 &&
             result.quat_x <= 16384 && result.quat_x >= -16384 &&
             result.quat_y <= 16384 && result.quat_y >= -16384 &&
             result.quat_z <= 16384 && result.quat_z >= -16384)
    else $error("quaternion part beyond one");

  a_valid_nonzero: assert property (@(posedge clk) disable iff (rst)
    done && !result.invalid |-> result.quat_w != 0 || result.quat_x != 0 ||
                                result.quat_y != 0 || result.quat_z != 0)
    else $error("valid result has zero length");
`endif

endmodule
